// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/pgg_pkg.sv =====
// ----------------------------------------------------------------------------
// pgg_pkg
// Types, constants and the arctangent table of the go-to-goal controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pgg_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_GOAL_X    = 3'd0;
  localparam logic [2:0] REG_GOAL_Y    = 3'd1;
  localparam logic [2:0] REG_TOLERANCE = 3'd2;
  localparam logic [2:0] REG_LIN_GAIN  = 3'd3;
  localparam logic [2:0] REG_ANG_GAIN  = 3'd4;

  // Register reset values
  localparam logic [14:0] TOL_RST   = 15'd3;
  localparam logic [11:0] LGAIN_RST = 12'd256;
  localparam logic [11:0] AGAIN_RST = 12'd1024;

  // Arithmetic sizes
  localparam int ATAN_LEN   = 24;  // entries in the arctangent table
  localparam int ATAN_IDX_W = 5;
  localparam int SQRT_STEPS = 17;  // result bits of the root of a 34-bit value
  localparam int CW         = 27;  // CORDIC x/y width
  localparam logic signed [31:0] HALF_PI_Q28 = 32'sd421657428;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MDX,
    ST_MDY,
    ST_MTOL,
    ST_TEST,
    ST_ITER,
    ST_ROUND,
    ST_MLIN,
    ST_MANG,
    ST_ASAT,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    MS_NONE,
    MS_DX,
    MS_DY,
    MS_TOL,
    MS_LIN,
    MS_ANG
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    mul_sel_t mul_sel;
    logic     sq_first;
    logic     sq_add;
    logic     test;
    logic     iter;
    logic     round;
    logic     lin_sat;
    logic     ang_sat;
  } ctl_t;

  // atan(2^-i) in Q3.28
  function automatic logic signed [31:0] atan_q28(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [31:0] v;
    begin
      case (idx)
        5'd0:    v = 32'sd210828714;
        5'd1:    v = 32'sd124459457;
        5'd2:    v = 32'sd65760959;
        5'd3:    v = 32'sd33381290;
        5'd4:    v = 32'sd16755422;
        5'd5:    v = 32'sd8385879;
        5'd6:    v = 32'sd4193963;
        5'd7:    v = 32'sd2097109;
        5'd8:    v = 32'sd1048571;
        5'd9:    v = 32'sd524287;
        5'd10:   v = 32'sd262144;
        5'd11:   v = 32'sd131072;
        5'd12:   v = 32'sd65536;
        5'd13:   v = 32'sd32768;
        5'd14:   v = 32'sd16384;
        5'd15:   v = 32'sd8192;
        5'd16:   v = 32'sd4096;
        5'd17:   v = 32'sd2048;
        5'd18:   v = 32'sd1024;
        5'd19:   v = 32'sd512;
        5'd20:   v = 32'sd256;
        5'd21:   v = 32'sd128;
        5'd22:   v = 32'sd64;
        5'd23:   v = 32'sd32;
        default: v = 32'sd0;
      endcase
      return v;
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pgg_seq.sv =====
// ----------------------------------------------------------------------------
// pgg_seq
// Sequencer: steps one request through multiply, test, iterate and scale.
// ----------------------------------------------------------------------------
`default_nettype none

module pgg_seq #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  input  wire logic                   out_ready,
  input  wire logic                   stop,
  output logic                        in_ready,
  output logic                        out_valid,
  output pgg_pkg::ctl_t               ctl,
  output logic [$clog2((CORDIC_ITERATIONS < pgg_pkg::ATAN_LEN ? CORDIC_ITERATIONS :
                 pgg_pkg::ATAN_LEN) > pgg_pkg::SQRT_STEPS ? (CORDIC_ITERATIONS <
                 pgg_pkg::ATAN_LEN ? CORDIC_ITERATIONS : pgg_pkg::ATAN_LEN) :
                 pgg_pkg::SQRT_STEPS)-1:0] cnt
);

  localparam int CORDIC_STEPS = (CORDIC_ITERATIONS < pgg_pkg::ATAN_LEN) ?
                                CORDIC_ITERATIONS : pgg_pkg::ATAN_LEN;
  localparam int ITER_MAX     = (CORDIC_STEPS > pgg_pkg::SQRT_STEPS) ?
                                CORDIC_STEPS : pgg_pkg::SQRT_STEPS;
  localparam int CNT_W        = $clog2(ITER_MAX);

  pgg_pkg::state_t   state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              last_iter;

  assign last_iter = (cnt_r == CNT_W'(ITER_MAX - 1));
  assign cnt       = cnt_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pgg_pkg::ST_IDLE:  if (in_valid) state_nxt = pgg_pkg::ST_MDX;
      pgg_pkg::ST_MDX:   state_nxt = pgg_pkg::ST_MDY;
      pgg_pkg::ST_MDY:   state_nxt = pgg_pkg::ST_MTOL;
      pgg_pkg::ST_MTOL:  state_nxt = pgg_pkg::ST_TEST;
      pgg_pkg::ST_TEST:  state_nxt = stop ? pgg_pkg::ST_OUT : pgg_pkg::ST_ITER;
      pgg_pkg::ST_ITER:  if (last_iter) state_nxt = pgg_pkg::ST_ROUND;
      pgg_pkg::ST_ROUND: state_nxt = pgg_pkg::ST_MLIN;
      pgg_pkg::ST_MLIN:  state_nxt = pgg_pkg::ST_MANG;
      pgg_pkg::ST_MANG:  state_nxt = pgg_pkg::ST_ASAT;
      pgg_pkg::ST_ASAT:  state_nxt = pgg_pkg::ST_OUT;
      pgg_pkg::ST_OUT:   if (out_ready) state_nxt = pgg_pkg::ST_IDLE;
      default:           state_nxt = pgg_pkg::ST_IDLE;
    endcase
  end

  // Step counter: clear on the test, advance per iteration
  always_comb begin
    cnt_nxt = cnt_r;
    if (state_r == pgg_pkg::ST_TEST) begin
      cnt_nxt = '0;
    end else if (state_r == pgg_pkg::ST_ITER) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  // Outputs per state
  always_comb begin
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    ctl         = '0;
    ctl.mul_sel = pgg_pkg::MS_NONE;
    case (state_r)
      pgg_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        ctl.load = in_valid;
      end
      pgg_pkg::ST_MDX:   ctl.mul_sel = pgg_pkg::MS_DX;
      pgg_pkg::ST_MDY: begin
        ctl.mul_sel  = pgg_pkg::MS_DY;
        ctl.sq_first = 1'b1;
      end
      pgg_pkg::ST_MTOL: begin
        ctl.mul_sel = pgg_pkg::MS_TOL;
        ctl.sq_add  = 1'b1;
      end
      pgg_pkg::ST_TEST:  ctl.test  = 1'b1;
      pgg_pkg::ST_ITER:  ctl.iter  = 1'b1;
      pgg_pkg::ST_ROUND: ctl.round = 1'b1;
      pgg_pkg::ST_MLIN:  ctl.mul_sel = pgg_pkg::MS_LIN;
      pgg_pkg::ST_MANG: begin
        ctl.mul_sel = pgg_pkg::MS_ANG;
        ctl.lin_sat = 1'b1;
      end
      pgg_pkg::ST_ASAT:  ctl.ang_sat = 1'b1;
      pgg_pkg::ST_OUT:   out_valid = 1'b1;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pgg_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pgg_dp.sv =====
// ----------------------------------------------------------------------------
// pgg_dp
// Datapath: configuration, shared multiplier, root and CORDIC step units,
// saturation and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module pgg_dp #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire pgg_pkg::ctl_t       ctl,
  input  wire logic [$clog2((CORDIC_ITERATIONS < pgg_pkg::ATAN_LEN ? CORDIC_ITERATIONS :
                 pgg_pkg::ATAN_LEN) > pgg_pkg::SQRT_STEPS ? (CORDIC_ITERATIONS <
                 pgg_pkg::ATAN_LEN ? CORDIC_ITERATIONS : pgg_pkg::ATAN_LEN) :
                 pgg_pkg::SQRT_STEPS)-1:0] cnt,
  input  wire logic                cfg_we,
  input  wire logic [2:0]          cfg_idx,
  input  wire logic [15:0]         cfg_wdata,
  input  wire logic signed [15:0]  in_pose_x,
  input  wire logic signed [15:0]  in_pose_y,
  input  wire logic signed [14:0]  in_pose_heading,
  output logic                     stop,
  output logic signed [15:0]       out_linear_velocity,
  output logic signed [15:0]       out_angular_velocity,
  output logic                     out_goal_reached
);

  localparam int CORDIC_STEPS = (CORDIC_ITERATIONS < pgg_pkg::ATAN_LEN) ?
                                CORDIC_ITERATIONS : pgg_pkg::ATAN_LEN;
  localparam int ITER_MAX     = (CORDIC_STEPS > pgg_pkg::SQRT_STEPS) ?
                                CORDIC_STEPS : pgg_pkg::SQRT_STEPS;
  localparam int CNT_W        = $clog2(ITER_MAX);
  localparam int CW           = pgg_pkg::CW;

  // Configuration and latch
  logic signed [15:0] goal_x_r, goal_y_r;
  logic [14:0]        tol_r;
  logic [11:0]        lgain_r, again_r;
  logic               latch_r;

  // Working registers
  logic signed [16:0] dx_r, dy_r;
  logic signed [14:0] hd_r;
  logic signed [35:0] prod_r;
  logic [33:0]        sq_r;
  logic [33:0]        rem_r;
  logic [34:0]        root_r, bit_r;
  logic signed [CW-1:0] x_r, y_r;
  logic signed [31:0] z_r;
  logic               zero_r;
  logic signed [15:0] bear_r;
  logic signed [15:0] lin_r, ang_r;
  logic               reached_r;

  // Shared multiplier operands
  logic signed [17:0] mul_a, mul_b;
  logic signed [16:0] ang_err;

  // Root step
  logic [34:0] sq_t;
  logic        sq_ge;
  logic [33:0] rem_nxt;
  logic [34:0] root_nxt;

  // CORDIC step and entry rotation
  logic signed [CW-1:0] xs, ys, x_nxt, y_nxt, x0, y0;
  logic signed [CW-1:0] xi, yi;
  logic signed [31:0]   zi, z_nxt, at;
  logic signed [31:0]   z_rnd;

  // Saturation
  logic [27:0]        lin_full;
  logic signed [23:0] ang_full;
  logic signed [15:0] lin_nxt, ang_nxt;

  logic tol_hit;

  // Configuration write and latch update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_x_r <= '0;
      goal_y_r <= '0;
      tol_r    <= pgg_pkg::TOL_RST;
      lgain_r  <= pgg_pkg::LGAIN_RST;
      again_r  <= pgg_pkg::AGAIN_RST;
      latch_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          pgg_pkg::REG_GOAL_X:    goal_x_r <= cfg_wdata;
          pgg_pkg::REG_GOAL_Y:    goal_y_r <= cfg_wdata;
          pgg_pkg::REG_TOLERANCE: tol_r    <= cfg_wdata[14:0];
          pgg_pkg::REG_LIN_GAIN:  lgain_r  <= cfg_wdata[11:0];
          pgg_pkg::REG_ANG_GAIN:  again_r  <= cfg_wdata[11:0];
          default: begin
            tol_r <= tol_r;
          end
        endcase
      end
      // A new goal clears the latch; a stop sets it
      if (cfg_we && (cfg_idx inside {pgg_pkg::REG_GOAL_X, pgg_pkg::REG_GOAL_Y})) begin
        latch_r <= 1'b0;
      end else if (ctl.test && stop) begin
        latch_r <= 1'b1;
      end
    end
  end

  // Stop test: squared distance against squared tolerance
  assign tol_hit = (sq_r < prod_r[33:0]);
  assign stop    = latch_r | tol_hit;

  // Shared multiplier operand select
  assign ang_err = {bear_r[15], bear_r} - {{2{hd_r[14]}}, hd_r};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctl.mul_sel)
      pgg_pkg::MS_DX: begin
        mul_a = {dx_r[16], dx_r};
        mul_b = {dx_r[16], dx_r};
      end
      pgg_pkg::MS_DY: begin
        mul_a = {dy_r[16], dy_r};
        mul_b = {dy_r[16], dy_r};
      end
      pgg_pkg::MS_TOL: begin
        mul_a = {3'b000, tol_r};
        mul_b = {3'b000, tol_r};
      end
      pgg_pkg::MS_LIN: begin
        mul_a = {1'b0, root_r[16:0]};
        mul_b = {6'b0, lgain_r};
      end
      pgg_pkg::MS_ANG: begin
        mul_a = {ang_err[16], ang_err};
        mul_b = {6'b0, again_r};
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  // Root step: one result bit per cycle
  assign sq_t     = root_r + bit_r;
  assign sq_ge    = ({1'b0, rem_r} >= sq_t);
  assign rem_nxt  = sq_ge ? (rem_r - sq_t[33:0]) : rem_r;
  assign root_nxt = sq_ge ? ((root_r >> 1) + bit_r) : (root_r >> 1);

  // Entry rotation into the right half plane
  assign x0 = {{2{dx_r[16]}}, dx_r, 8'b0};
  assign y0 = {{2{dy_r[16]}}, dy_r, 8'b0};

  always_comb begin
    xi = x0;
    yi = y0;
    zi = '0;
    if (dx_r[16]) begin
      if (!dy_r[16]) begin
        xi = y0;
        yi = -x0;
        zi = pgg_pkg::HALF_PI_Q28;
      end else begin
        xi = -y0;
        yi = x0;
        zi = -pgg_pkg::HALF_PI_Q28;
      end
    end
  end

  // CORDIC vectoring step: rotate toward y = 0
  assign xs = x_r >>> cnt;
  assign ys = y_r >>> cnt;
  assign at = pgg_pkg::atan_q28(pgg_pkg::ATAN_IDX_W'(cnt));

  always_comb begin
    if (!y_r[CW-1]) begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + at;
    end else begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - at;
    end
  end

  // Round the angle to Q3.12
  assign z_rnd = z_r + 32'sd32768;

  // Saturate the scaled products
  assign lin_full = prod_r[35:8];
  assign ang_full = prod_r[35:12];

  always_comb begin
    if (|lin_full[27:15]) begin
      lin_nxt = 16'sh7FFF;
    end else begin
      lin_nxt = {1'b0, lin_full[14:0]};
    end
    if ((&ang_full[23:15]) || !(|ang_full[23:15])) begin
      ang_nxt = ang_full[15:0];
    end else if (ang_full[23]) begin
      ang_nxt = 16'sh8000;
    end else begin
      ang_nxt = 16'sh7FFF;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (ctl.load) begin
      dx_r <= {goal_x_r[15], goal_x_r} - {in_pose_x[15], in_pose_x};
      dy_r <= {goal_y_r[15], goal_y_r} - {in_pose_y[15], in_pose_y};
      hd_r <= in_pose_heading;
    end
    if (ctl.sq_first) begin
      sq_r <= prod_r[33:0];
    end else if (ctl.sq_add) begin
      sq_r <= sq_r + prod_r[33:0];
    end
    if (ctl.test) begin
      if (stop) begin
        lin_r     <= '0;
        ang_r     <= '0;
        reached_r <= 1'b1;
      end else begin
        reached_r <= 1'b0;
        rem_r     <= sq_r;
        root_r    <= '0;
        bit_r     <= 35'd1 << (2 * (pgg_pkg::SQRT_STEPS - 1));
        x_r       <= xi;
        y_r       <= yi;
        z_r       <= zi;
        zero_r    <= (dx_r == '0) && (dy_r == '0);
      end
    end
    if (ctl.iter) begin
      if (cnt < CNT_W'(pgg_pkg::SQRT_STEPS)) begin
        rem_r  <= rem_nxt;
        root_r <= root_nxt;
        bit_r  <= bit_r >> 2;
      end
      if (cnt < CNT_W'(CORDIC_STEPS)) begin
        x_r <= x_nxt;
        y_r <= y_nxt;
        z_r <= z_nxt;
      end
    end
    if (ctl.round) begin
      bear_r <= zero_r ? 16'sd0 : z_rnd[31:16];
    end
    if (ctl.lin_sat) begin
      lin_r <= lin_nxt;
    end
    if (ctl.ang_sat) begin
      ang_r <= ang_nxt;
    end
  end

  assign out_linear_velocity  = lin_r;
  assign out_angular_velocity = ang_r;
  assign out_goal_reached     = reached_r;

endmodule

`default_nettype wire

// ===== rtl/proportional_go_to_goal_controller.sv =====
// ----------------------------------------------------------------------------
// proportional_go_to_goal_controller
// Proportional go-to-goal controller: distance and bearing to a goal,
// velocity commands with stop latch.
// ----------------------------------------------------------------------------
//  Port group | Dir | Handshake          | Payload
//  in_        | in  | in_valid/in_ready  | pose_x, pose_y, pose_heading
//  out_       | out | out_valid/out_ready| linear_velocity, angular_velocity,
//             |     |                    | goal_reached
//  cfg_       | in  | cfg_we             | cfg_idx, cfg_wdata
//
//  One request at a time: squares and stop test, then the shared root/CORDIC
//  loop, then rounding and scaling; a stopped request goes from the stop test
//  straight to the result, and the next request is taken only after the result
//  has been accepted. Reset (rst_n low, synchronous) restores the register
//  defaults and clears the reached latch. A stalled result holds until
//  out_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module proportional_go_to_goal_controller #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_pose_x,
  input  wire logic signed [15:0] in_pose_y,
  input  wire logic signed [14:0] in_pose_heading,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_linear_velocity,
  output logic signed [15:0]      out_angular_velocity,
  output logic                    out_goal_reached,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_idx,
  input  wire logic [15:0]        cfg_wdata
);

  localparam int CORDIC_STEPS = (CORDIC_ITERATIONS < pgg_pkg::ATAN_LEN) ?
                                CORDIC_ITERATIONS : pgg_pkg::ATAN_LEN;
  localparam int ITER_MAX     = (CORDIC_STEPS > pgg_pkg::SQRT_STEPS) ?
                                CORDIC_STEPS : pgg_pkg::SQRT_STEPS;
  localparam int CNT_W        = $clog2(ITER_MAX);

  pgg_pkg::ctl_t    ctl;
  logic [CNT_W-1:0] cnt;
  logic             stop;

  // Sequencer
  pgg_seq #(
    .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .stop      (stop),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .ctl       (ctl),
    .cnt       (cnt)
  );

  // Datapath
  pgg_dp #(
    .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .ctl                  (ctl),
    .cnt                  (cnt),
    .cfg_we               (cfg_we),
    .cfg_idx              (cfg_idx),
    .cfg_wdata            (cfg_wdata),
    .in_pose_x            (in_pose_x),
    .in_pose_y            (in_pose_y),
    .in_pose_heading      (in_pose_heading),
    .stop                 (stop),
    .out_linear_velocity  (out_linear_velocity),
    .out_angular_velocity (out_angular_velocity),
    .out_goal_reached     (out_goal_reached)
  );

endmodule

`default_nettype wire

// ===== rtl/pgg_checker.sv =====
// ----------------------------------------------------------------------------
// pgg_checker
// Port-level checks on the go-to-goal controller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pgg_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [15:0] out_linear_velocity,
  input wire logic signed [15:0] out_angular_velocity,
  input wire logic               out_goal_reached
);

  logic        out_stall;
  logic        stopped_out;
  logic        cmd_zero;
  logic [32:0] out_cmd;

  // Collect the result terms used below
  assign out_stall   = out_valid && !out_ready;
  assign stopped_out = out_valid && out_goal_reached;
  assign cmd_zero    = (out_linear_velocity == 16'sd0) && (out_angular_velocity == 16'sd0);
  assign out_cmd     = {out_linear_velocity, out_angular_velocity, out_goal_reached};

  // No new request is taken while a result waits
  `ASSERT_SAME(a_no_overlap, clk, rst_n, out_valid, !in_ready)
  // An accepted request keeps the block busy in the next cycle
  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready && !out_valid)
  // A stopped result carries zero commands
  `ASSERT_SAME(a_reached_zero, clk, rst_n, stopped_out, cmd_zero)
  // Forward speed is never negative
  `ASSERT_SAME(a_lin_nonneg, clk, rst_n, out_valid, !out_linear_velocity[15])
  // A stalled result holds
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_cmd))

endmodule

bind proportional_go_to_goal_controller pgg_checker u_pgg_checker (.*);

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the go-to-goal controller. Pose requests with
// directed corner cases and random approach trajectories are driven through
// the valid/ready channels while goal, tolerance and gains are reprogrammed
// between phases. A scoreboard predicts each velocity command and the reached
// latch and checks every returned command in order.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CORDIC_STEPS  = 16;
  localparam int SETTLE_CYCLES = 40;    // longer than the request latency
  localparam int QUIET_LIMIT   = 4000;
  localparam int POSE_TARGET   = 1050;
  localparam int CALM_FROM     = 900;   // no idling on either side after this
  localparam int HEADING_MAX   = 12868; // pi in Q3.12
  localparam logic [2:0] REG_SPARE_LO = 3'd5;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [14:0] heading;
  } pose_t;

  typedef struct packed {
    logic signed [15:0] lin_vel;
    logic signed [15:0] ang_vel;
    logic               reached;
  } command_t;

  // Mirror of the controller: registers, stop latch and pending commands
  class command_scoreboard;
    logic signed [15:0] goal_x;
    logic signed [15:0] goal_y;
    logic [14:0]        tolerance;
    logic [11:0]        lin_gain;
    logic [11:0]        ang_gain;
    bit                 reached_latch;
    int                 cordic_steps;
    longint             atan_steps[24];
    command_t           expected_cmds[$];
    int                 errors;
    int                 reported;
    int                 reached_seen;

    function new(int steps);
      cordic_steps  = steps;
      atan_steps    = '{210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
                        4193963, 2097109, 1048571, 524287, 262144, 131072,
                        65536, 32768, 16384, 8192, 4096, 2048,
                        1024, 512, 256, 128, 64, 32};
      goal_x        = '0;
      goal_y        = '0;
      tolerance     = pgg_pkg::TOL_RST;
      lin_gain      = pgg_pkg::LGAIN_RST;
      ang_gain      = pgg_pkg::AGAIN_RST;
      reached_latch = 1'b0;
      errors        = 0;
      reported      = 0;
      reached_seen  = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        pgg_pkg::REG_GOAL_X: begin
          goal_x        = data;
          reached_latch = 1'b0;
        end
        pgg_pkg::REG_GOAL_Y: begin
          goal_y        = data;
          reached_latch = 1'b0;
        end
        pgg_pkg::REG_TOLERANCE: tolerance = data[14:0];
        pgg_pkg::REG_LIN_GAIN:  lin_gain  = data[11:0];
        pgg_pkg::REG_ANG_GAIN:  ang_gain  = data[11:0];
        default: ;
      endcase
    endfunction

    // Bit-by-bit floor of the square root
    function longint root_floor(longint n);
      longint r;
      longint t;
      r = 0;
      for (int k = 17; k >= 0; k--) begin
        t = r | (longint'(1) << k);
        if (t * t <= n) r = t;
      end
      return r;
    endfunction

    // Bearing atan2(dy, dx) in Q3.12 by vectoring rotations
    function longint bearing_q12(longint dx, longint dy);
      longint x, y, z, t, xs, ys;
      if (dx == 0 && dy == 0) return 0;
      x = dx * 256;
      y = dy * 256;
      z = 0;
      // fold the left half plane over by a quarter turn
      if (x < 0) begin
        if (y >= 0) begin
          t = x; x = y; y = -t; z = longint'(pgg_pkg::HALF_PI_Q28);
        end else begin
          t = x; x = -y; y = t; z = -longint'(pgg_pkg::HALF_PI_Q28);
        end
      end
      for (int i = 0; i < cordic_steps && i < 24; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x += ys; y -= xs; z += atan_steps[i];
        end else begin
          x -= ys; y += xs; z -= atan_steps[i];
        end
      end
      return (z + 32768) >>> 16;
    endfunction

    function command_t predict_command(pose_t p);
      longint   dx, dy, sq, tol_sq, distance, lin, ang;
      command_t c;
      dx     = longint'(goal_x) - longint'(p.x);
      dy     = longint'(goal_y) - longint'(p.y);
      sq     = dx * dx + dy * dy;
      tol_sq = longint'(tolerance) * longint'(tolerance);
      // stop once inside the tolerance circle, and stay stopped
      if (reached_latch || sq < tol_sq) begin
        reached_latch = 1'b1;
        c.lin_vel = '0;
        c.ang_vel = '0;
        c.reached = 1'b1;
        return c;
      end
      distance = root_floor(sq);
      lin      = (distance * longint'(lin_gain)) >> 8;
      if (lin > 32767) lin = 32767;
      ang = (longint'(ang_gain) * (bearing_q12(dx, dy) - longint'(p.heading))) >>> 12;
      if (ang > 32767) ang = 32767;
      if (ang < -32768) ang = -32768;
      c.lin_vel = 16'(lin);
      c.ang_vel = 16'(ang);
      c.reached = 1'b0;
      return c;
    endfunction

    function void note_pose(pose_t p);
      expected_cmds.push_back(predict_command(p));
    endfunction

    function int pending();
      return expected_cmds.size();
    endfunction

    function void check_command(command_t got);
      command_t want;
      bit       bad;
      if (expected_cmds.size() == 0) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("tb_top: unexpected command lin=%0d ang=%0d reached=%0b",
                   got.lin_vel, got.ang_vel, got.reached);
        end
        return;
      end
      want = expected_cmds.pop_front();
      if (want.reached) reached_seen++;
      bad = (got.lin_vel !== want.lin_vel) || (got.ang_vel !== want.ang_vel) ||
            (got.reached !== want.reached);
      if (bad) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("tb_top: command mismatch: expected lin=%0d ang=%0d reached=%0b,",
                   want.lin_vel, want.ang_vel, want.reached);
          $display("tb_top:   got lin=%0d ang=%0d reached=%0b",
                   got.lin_vel, got.ang_vel, got.reached);
        end
      end
    endfunction

    function void close_out();
      if (expected_cmds.size() > 0) begin
        errors += expected_cmds.size();
        $display("tb_top: %0d commands never returned", expected_cmds.size());
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] in_pose_x = '0;
  logic signed [15:0] in_pose_y = '0;
  logic signed [14:0] in_pose_heading = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] out_linear_velocity;
  logic signed [15:0] out_angular_velocity;
  logic               out_goal_reached;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_idx = '0;
  logic [15:0]        cfg_wdata = '0;

  command_scoreboard sb;
  bit idle_on = 1'b1;
  int poses_sent = 0;
  int commands_seen = 0;
  int reg_writes = 0;
  int settings_run = 0;
  int quiet_cycles = 0;
  int stall_left = 0;

  proportional_go_to_goal_controller #(
    .CORDIC_ITERATIONS(CORDIC_STEPS)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_pose_x           (in_pose_x),
    .in_pose_y           (in_pose_y),
    .in_pose_heading     (in_pose_heading),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_linear_velocity (out_linear_velocity),
    .out_angular_velocity(out_angular_velocity),
    .out_goal_reached    (out_goal_reached),
    .cfg_we              (cfg_we),
    .cfg_idx             (cfg_idx),
    .cfg_wdata           (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Check returned commands and stall the result side in bursts
  always @(posedge clk) begin : cmd_rx
    command_t got;
    if (rst_n && out_valid && out_ready) begin
      got.lin_vel = out_linear_velocity;
      got.ang_vel = out_angular_velocity;
      got.reached = out_goal_reached;
      sb.check_command(got);
      commands_seen++;
    end
    if (stall_left > 0) stall_left--;
    else if (idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 5);
    out_ready <= (stall_left == 0);
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top: watchdog expired with %0d commands outstanding", sb.pending());
      $display("tb_top: FAIL");
      $finish;
    end
  end

  function automatic int srand(int lo, int hi);
    return int'($urandom_range(0, hi - lo)) + lo;
  endfunction

  function automatic int clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  function automatic int pick_heading();
    if (srand(0, 9) == 0) return srand(-16384, 16383);
    return srand(-HEADING_MAX, HEADING_MAX);
  endfunction

  function automatic int pick_coord();
    case (srand(0, 7))
      0:       return -32768;
      1:       return 32767;
      default: return srand(-32768, 32767);
    endcase
  endfunction

  function automatic int pick_gain();
    case (srand(0, 7))
      0:       return 0;
      1:       return 4095;
      default: return srand(1, 4094);
    endcase
  endfunction

  function automatic int pick_tolerance();
    case (srand(0, 7))
      0:       return 0;
      1:       return 32767;
      2:       return srand(1, 20);
      default: return srand(1, 3000);
    endcase
  endfunction

  // Send one pose request, with an optional idle burst ahead of it
  task automatic send_pose(input int x, input int y, input int h);
    pose_t p;
    int    gap;
    p.x       = 16'(x);
    p.y       = 16'(y);
    p.heading = 15'(h);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_pose_x       <= p.x;
    in_pose_y       <= p.y;
    in_pose_heading <= p.heading;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_pose(p);
    poses_sent++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input int val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= 16'(val);
    @(posedge clk);
    sb.set_reg(idx, 16'(val));
    reg_writes++;
  endtask

  task automatic end_writes();
    cfg_we <= 1'b0;
  endtask

  // Hold off new requests until every command is back
  task automatic wait_all_commands();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
  endtask

  task automatic drain();
    wait_all_commands();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_random_setting();
    write_reg(pgg_pkg::REG_TOLERANCE, pick_tolerance());
    write_reg(pgg_pkg::REG_LIN_GAIN, pick_gain());
    write_reg(pgg_pkg::REG_ANG_GAIN, pick_gain());
    if (srand(0, 5) == 0) write_reg(3'(srand(REG_SPARE_LO, REG_SPARE_HI)), srand(0, 65535));
    write_reg(pgg_pkg::REG_GOAL_X, pick_coord());
    write_reg(pgg_pkg::REG_GOAL_Y, pick_coord());
    end_writes();
    settings_run++;
  endtask

  initial begin
    longint ox, oy;
    int     phase, k, n_items, sel, t, gx, gy;
    sb = new(CORDIC_STEPS);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: goal at the origin, extremes of pose and heading
    send_pose(-32768, -32768, HEADING_MAX);
    send_pose(32767, 32767, -HEADING_MAX);
    send_pose(32767, -32768, -16384);
    send_pose(-32768, 32767, 16383);
    send_pose(100, -5, 0);
    send_pose(2, 2, 0);          // inside the default tolerance
    send_pose(-32768, 0, 0);     // latch keeps the stop
    drain();

    // Far corner goal, zero tolerance, full gains, writes to spare indexes
    write_reg(pgg_pkg::REG_GOAL_X, -32768);
    write_reg(pgg_pkg::REG_GOAL_Y, 32767);
    write_reg(pgg_pkg::REG_TOLERANCE, 0);
    write_reg(pgg_pkg::REG_LIN_GAIN, 4095);
    write_reg(pgg_pkg::REG_ANG_GAIN, 4095);
    write_reg(REG_SPARE_LO, 16'hFFFF);
    write_reg(REG_SPARE_HI, 16'h1234);
    end_writes();
    send_pose(32767, -32768, -HEADING_MAX);  // longest offset, speed saturates
    send_pose(-32768, 32767, 0);             // on the goal, never stops at zero tolerance
    send_pose(-32767, 32767, 100);
    send_pose(32767, -32768, -16384);
    drain();

    // Widest tolerance with zero gains
    write_reg(pgg_pkg::REG_GOAL_X, 32767);
    write_reg(pgg_pkg::REG_GOAL_Y, -32768);
    write_reg(pgg_pkg::REG_TOLERANCE, 32767);
    write_reg(pgg_pkg::REG_LIN_GAIN, 0);
    write_reg(pgg_pkg::REG_ANG_GAIN, 0);
    end_writes();
    send_pose(-32768, 32767, 0);
    send_pose(0, 0, 0);
    send_pose(32667, -32668, 0);
    drain();

    // Unit tolerance around the origin: axis directions and the latch clear
    write_reg(pgg_pkg::REG_GOAL_X, 0);
    write_reg(pgg_pkg::REG_GOAL_Y, 0);
    write_reg(pgg_pkg::REG_TOLERANCE, 1);
    write_reg(pgg_pkg::REG_LIN_GAIN, pgg_pkg::LGAIN_RST);
    write_reg(pgg_pkg::REG_ANG_GAIN, pgg_pkg::AGAIN_RST);
    end_writes();
    send_pose(0, 0, 0);
    send_pose(1, 0, 0);
    drain();
    write_reg(pgg_pkg::REG_GOAL_X, 0);
    end_writes();
    send_pose(1, 0, 0);
    send_pose(0, -1, HEADING_MAX);
    send_pose(0, 1, -HEADING_MAX);
    send_pose(-1, -1, 0);
    send_pose(1, 1, 0);

    // Random settings, each with approach trajectories plus noise
    phase = 0;
    while (poses_sent < POSE_TARGET) begin
      if (poses_sent >= CALM_FROM) idle_on = 1'b0;
      drain();
      program_random_setting();
      gx      = int'(sb.goal_x);
      gy      = int'(sb.goal_y);
      n_items = srand(30, 60);
      ox      = srand(-65535, 65535);
      oy      = srand(-65535, 65535);
      for (k = 0; k < n_items; k++) begin
        if ((phase == 1 && k == n_items / 2) || srand(0, 149) == 0) wait_all_commands();
        sel = srand(0, 19);
        if (sel < 2) begin
          send_pose(srand(-32768, 32767), srand(-32768, 32767), pick_heading());
        end else if (sel < 4) begin
          t = int'(sb.tolerance) * 2 + 2;
          send_pose(clamp16(gx + srand(-t, t)), clamp16(gy + srand(-t, t)), pick_heading());
        end else begin
          // advance toward the goal, restart now and then
          if (srand(0, 14) == 0) begin
            ox = srand(-65535, 65535);
            oy = srand(-65535, 65535);
          end
          send_pose(clamp16(gx + ox), clamp16(gy + oy), pick_heading());
          ox = ox * srand(40, 95) / 100 + srand(-3, 3);
          oy = oy * srand(40, 95) / 100 + srand(-3, 3);
        end
      end
      phase++;
    end

    drain();
    sb.close_out();
    $display("tb_top: %0d pose requests, %0d commands checked, %0d of them stopped at goal",
             poses_sent, commands_seen, sb.reached_seen);
    $display("tb_top: %0d register writes over %0d random goal settings, %0d errors",
             reg_writes, settings_run, sb.errors);
    if (sb.errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
